FILE: hdl/cma_pkg.sv
// cma_pkg: shared constants and control types for the centered moving average
// used by cma_ring and centered_moving_average; no dependencies
package cma_pkg;

  localparam int MAX_HALF_WIDTH = 15;
  localparam int SAMPLE_BITS    = 16;
  localparam int CFG_BITS       = 4;

  localparam logic [CFG_BITS-1:0] RESET_HALF_WIDTH = 4'd3;

  // control of the sample ring memory for one cycle
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } ring_ctl_t;

endpackage

FILE: hdl/cma_ring.sv
// cma_ring: ring memory of recent samples, one write and one registered read per cycle
// valid bit per entry, cleared at once; invalid entries read as zero; uses cma_pkg
module cma_ring #(
  parameter int DEPTH  = 2 * cma_pkg::MAX_HALF_WIDTH + 1,
  parameter int DATA_W = cma_pkg::SAMPLE_BITS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cma_pkg::ring_ctl_t       ctl,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_vld_r;

  // read-first: a read of the slot being written returns the old sample
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (ctl.clear) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? signed'(rd_data_r) : '0;

endmodule

FILE: hdl/cma_div.sv
// cma_div: radix-2 restoring divider, signed dividend by unsigned divisor
// quotient truncated toward zero, one bit per cycle; no package dependencies
module cma_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5,
  parameter int Q_W   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic             neg_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;
  logic [NUM_W-1:0] quo_full;

  assign mag    = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
      done_r <= (cnt_r == CNT_W'(1)) && !start;
    end
  end

  // dividend bits shift out of the top of quo_r as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quo_full = neg_r ? (~quo_r + NUM_W'(1)) : quo_r;
  assign quo      = signed'(quo_full[Q_W-1:0]);
  assign done     = done_r;

endmodule

FILE: hdl/centered_moving_average.sv
// centered_moving_average: box filter over a block, samples past the block edges counted as zero
// a result goes through S_UPD (or S_FRD and S_FSUB when flushing), the serial divider in S_DIV
// and S_OUT, where it waits for out_ready before the output register is loaded
// in_ready is high only in S_IDLE: no new sample is taken until the last one is through
// a half_width write re-sums the window from memory in state S_SUM
// reset: synchronous, active low; empty window, half_width 3, no result pending
module centered_moving_average #(
  parameter int MAX_HALF_WIDTH = cma_pkg::MAX_HALF_WIDTH,
  parameter int SAMPLE_BITS    = cma_pkg::SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic                          out_final_result,
  input  logic                          cfg_wr_en,
  input  logic [cma_pkg::CFG_BITS-1:0]  cfg_wr_data
);

  localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int PTR_X      = PTR_W + 1;
  localparam int W_BITS     = $clog2(MAX_HALF_WIDTH + 1);
  localparam int TAP_BITS   = W_BITS + 1;
  localparam int SUM_BITS   = SAMPLE_BITS + PTR_W;
  localparam int CMP_W      = (W_BITS > cma_pkg::CFG_BITS) ? W_BITS : cma_pkg::CFG_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_UPD  = 7'b0000010,
    S_FRD  = 7'b0000100,
    S_FSUB = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_SUM  = 7'b1000000
  } state_t;

  function automatic logic [W_BITS-1:0] sat_hw(input logic [cma_pkg::CFG_BITS-1:0] v);
    logic [CMP_W-1:0] v_ext;
    logic [CMP_W-1:0] m_ext;
    v_ext = CMP_W'(v);
    m_ext = CMP_W'(MAX_HALF_WIDTH);
    return (v_ext > m_ext) ? W_BITS'(m_ext) : W_BITS'(v_ext);
  endfunction

  // ring slot holding the sample of the given age, 0 being the newest
  function automatic logic [PTR_W-1:0] age_addr(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] age);
    logic [PTR_X-1:0] t;
    t = {1'b0, wp} - {1'b0, age} - PTR_X'(1);
    if (t[PTR_W]) begin
      t = t + PTR_X'(RING_DEPTH);
    end
    return t[PTR_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [W_BITS-1:0]            hw_r, hw_nxt;
  logic [PTR_W-1:0]             wp_r, wp_nxt;
  logic [PTR_W-1:0]             seen_r, seen_nxt;
  logic signed [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic                         last_r, last_nxt;
  logic [W_BITS-1:0]            fl_cnt_r, fl_cnt_nxt;
  logic [PTR_W-1:0]             k_r, k_nxt;
  logic                         pend_final_r, pend_final_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_average_r;
  logic                         out_final_r;

  cma_pkg::ring_ctl_t           ring_ctl;
  logic [PTR_W-1:0]             ring_rd_addr;
  logic signed [SAMPLE_BITS-1:0] ring_rd_data;

  logic                         div_start;
  logic signed [SUM_BITS-1:0]   div_num;
  logic                         div_done;
  logic signed [SAMPLE_BITS-1:0] div_quo;

  logic [TAP_BITS-1:0]          taps;
  logic [PTR_W-1:0]             two_w;
  logic                         emit;
  logic [W_BITS-1:0]            flush_start;
  logic signed [SUM_BITS-1:0]   rd_ext;
  logic signed [SUM_BITS-1:0]   x_ext;
  logic signed [SUM_BITS-1:0]   sum_upd;
  logic signed [SUM_BITS-1:0]   sum_sub;
  logic signed [SUM_BITS-1:0]   sum_acc;
  logic                         out_load;

  assign taps        = {hw_r, 1'b1};
  assign two_w       = PTR_W'({hw_r, 1'b0});
  assign emit        = seen_r > PTR_W'(hw_r);
  assign flush_start = emit ? hw_r : W_BITS'(seen_r);
  assign rd_ext      = SUM_BITS'(ring_rd_data);
  assign x_ext       = SUM_BITS'(x_r);
  assign sum_upd     = sum_r + x_ext - rd_ext;
  assign sum_sub     = sum_r - rd_ext;
  assign sum_acc     = sum_r + rd_ext;
  assign div_num     = (state_r == S_UPD) ? sum_upd : sum_sub;
  assign in_ready    = (state_r == S_IDLE);

  cma_ring #(
    .DEPTH  (RING_DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .wr_addr (wp_r),
    .wr_data (in_sample),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  cma_div #(
    .NUM_W (SUM_BITS),
    .DEN_W (TAP_BITS),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (taps),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    hw_nxt         = hw_r;
    wp_nxt         = wp_r;
    seen_nxt       = seen_r;
    sum_nxt        = sum_r;
    x_nxt          = x_r;
    last_nxt       = last_r;
    fl_cnt_nxt     = fl_cnt_r;
    k_nxt          = k_r;
    pend_final_nxt = pend_final_r;
    ring_ctl       = '0;
    ring_rd_addr   = age_addr(wp_r, two_w);
    div_start      = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // write the new sample and fetch the one leaving the window
          ring_ctl.wr_en = 1'b1;
          ring_ctl.rd_en = 1'b1;
          x_nxt          = in_sample;
          last_nxt       = in_block_end;
          wp_nxt         = (wp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          seen_nxt       = (seen_r == PTR_W'(RING_DEPTH)) ? seen_r : seen_r + 1'b1;
          state_nxt      = S_UPD;
        end
      end
      S_UPD: begin
        sum_nxt    = sum_upd;
        fl_cnt_nxt = flush_start;
        if (emit) begin
          div_start      = 1'b1;
          pend_final_nxt = last_r && (flush_start == '0);
          state_nxt      = S_DIV;
        end else if (last_r) begin
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FRD: begin
        // the window shrinks by its oldest tap for each flushed center
        ring_ctl.rd_en = 1'b1;
        ring_rd_addr   = age_addr(wp_r, PTR_W'(fl_cnt_r) + PTR_W'(hw_r));
        state_nxt      = S_FSUB;
      end
      S_FSUB: begin
        sum_nxt        = sum_sub;
        div_start      = 1'b1;
        pend_final_nxt = (fl_cnt_r == W_BITS'(1));
        fl_cnt_nxt     = fl_cnt_r - 1'b1;
        state_nxt      = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (pend_final_r) begin
            ring_ctl.clear = 1'b1;
            wp_nxt         = '0;
            seen_nxt       = '0;
            sum_nxt        = '0;
            state_nxt      = S_IDLE;
          end else if (last_r && (fl_cnt_r != '0)) begin
            state_nxt = S_FRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUM: begin
        // re-sum ages 0..2w; read data arrives in the cycle after its age is issued
        ring_ctl.rd_en = (k_r <= two_w);
        ring_rd_addr   = age_addr(wp_r, k_r);
        if (k_r != '0) begin
          sum_nxt = sum_acc;
        end
        if (k_r == two_w + PTR_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      hw_nxt    = sat_hw(cfg_wr_data);
      k_nxt     = '0;
      sum_nxt   = '0;
      state_nxt = S_SUM;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hw_r         <= sat_hw(cma_pkg::RESET_HALF_WIDTH);
      wp_r         <= '0;
      seen_r       <= '0;
      sum_r        <= '0;
      last_r       <= 1'b0;
      fl_cnt_r     <= '0;
      k_r          <= '0;
      pend_final_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hw_r         <= hw_nxt;
      wp_r         <= wp_nxt;
      seen_r       <= seen_nxt;
      sum_r        <= sum_nxt;
      last_r       <= last_nxt;
      fl_cnt_r     <= fl_cnt_nxt;
      k_r          <= k_nxt;
      pend_final_r <= pend_final_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (out_load) begin
      out_average_r <= div_quo;
      out_final_r   <= pend_final_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average      = out_average_r;
  assign out_final_result = out_final_r;

`ifndef SYNTH
  a_final_clears_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && pend_final_r) |=> (wp_r == '0 && seen_r == '0 && sum_r == '0))
    else $error("block state not cleared after final result");

  a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cfg_wr_en) |=> (state_r == S_UPD))
    else $error("accepted request did not start a window update");

  a_ring_pointers_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r <= PTR_W'(RING_DEPTH - 1)) && (seen_r <= PTR_W'(RING_DEPTH)))
    else $error("ring pointer or fill count out of range");
`endif

endmodule
